// ----- design/vtvm_pkg.sv -----
// vtvm_pkg: shared types and constants of the vertex transform and viewport map
// used by vtvm_div and vertex_transform_viewport_map_core
`default_nettype none

package vtvm_pkg;

   localparam int MATRIX_SIZE = 4;
   localparam int FRAC_BITS   = 16;
   localparam int ENTRY_COUNT = MATRIX_SIZE * MATRIX_SIZE;
   localparam int QUO_BITS    = 32;

   typedef enum logic [2:0] {
      REG_WINDOW_LEFT     = 3'd0,
      REG_WINDOW_BOTTOM   = 3'd1,
      REG_WINDOW_RIGHT    = 3'd2,
      REG_WINDOW_TOP      = 3'd3,
      REG_VIEWPORT_WIDTH  = 3'd4,
      REG_VIEWPORT_HEIGHT = 3'd5
   } reg_index_type;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_VERTEX = 1'b1
   } kind_type;

   // transformed vertex carried alongside the division
   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic               window_error;
   } payload_type;

   // one axis of the restoring divider
   typedef struct packed {
      logic [63:0]           rem;
      logic [32:0]           den;
      logic [QUO_BITS-1:0]   quo;
      logic                  neg;
      logic                  ovf;
   } div_type;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

endpackage

`default_nettype wire

// ----- design/vertex_transform_viewport_map_core.sv -----
// vertex_transform_viewport_map_core: 4x4 matrix-vector transform with window to viewport map
// depends on vtvm_pkg and vtvm_div
`default_nettype none

// Takes one item per cycle and returns one result per vertex item via the input
// register, 16 parallel 32x32 multipliers, a two-level adder tree with floor
// shift and saturation, the window offset, the split 33x32 viewport scaling, the
// sign/overflow stage and a 32-stage restoring divider that yields one quotient
// bit per stage for both axes. Load items write the matrix in pipeline order, so
// a vertex sees every load that came before it and none after. The whole pipeline
// holds while a result waits on rsp_tready. The user must write configuration
// registers only when the block is idle; the block itself does not enforce this.
module vertex_transform_viewport_map_core
   import vtvm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // tdata: entry_index[3:0], entry_value[35:4], vertex_x[67:36], vertex_y[99:68],
   //        vertex_z[131:100], vertex_w[163:132], zero fill
   input  wire logic [167:0] req_tdata,
   input  wire logic [0:0]   req_tuser,   // kind
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: out_x, out_y, out_z, out_w, screen_x, screen_y, 32 bits each from bit 0
   output logic [191:0]      rsp_tdata,
   output logic [0:0]        rsp_tuser,   // window_error
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // configuration registers
   logic signed [31:0] win_left_ff, win_bottom_ff, win_right_ff, win_top_ff;
   logic signed [31:0] vp_width_ff, vp_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_bottom_ff <= '0;
         win_right_ff  <= 32'sd65536;
         win_top_ff    <= 32'sd65536;
         vp_width_ff   <= 32'sd65536;
         vp_height_ff  <= 32'sd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW_LEFT:     win_left_ff   <= csr_wdata;
            REG_WINDOW_BOTTOM:   win_bottom_ff <= csr_wdata;
            REG_WINDOW_RIGHT:    win_right_ff  <= csr_wdata;
            REG_WINDOW_TOP:      win_top_ff    <= csr_wdata;
            REG_VIEWPORT_WIDTH:  vp_width_ff   <= csr_wdata;
            REG_VIEWPORT_HEIGHT: vp_height_ff  <= csr_wdata;
            default: ;  // unknown index ignored
         endcase
      end
   end

   // window extents; the user must keep them fixed while items are in flight, the block does not enforce this
   logic signed [32:0] win_dx, win_dy;
   logic               win_err;
   assign win_dx  = 33'(win_right_ff) - 33'(win_left_ff);
   assign win_dy  = 33'(win_top_ff) - 33'(win_bottom_ff);
   assign win_err = (win_dx == '0) || (win_dy == '0);

   // stage 0: input register
   logic               s0_valid_ff;
   logic               s0_kind_ff;
   logic [3:0]         s0_index_ff;
   logic signed [31:0] s0_value_ff;
   logic signed [31:0] s0_vec_ff [0:MATRIX_SIZE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
      if (adv) begin
         s0_kind_ff  <= req_tuser[0];
         s0_index_ff <= req_tdata[3:0];
         s0_value_ff <= req_tdata[35:4];
         s0_vec_ff[0] <= req_tdata[67:36];
         s0_vec_ff[1] <= req_tdata[99:68];
         s0_vec_ff[2] <= req_tdata[131:100];
         s0_vec_ff[3] <= req_tdata[163:132];
      end
   end

   // matrix store, identity after reset, written as a load leaves stage 0
   logic signed [31:0] mat_ff [0:ENTRY_COUNT-1];
   always_ff @(posedge clock) begin
      for (int e = 0; e < ENTRY_COUNT; e++) begin
         if (reset) begin
            mat_ff[e] <= (e % (MATRIX_SIZE + 1) == 0) ? 32'(1 << FRAC_BITS) : '0;
         end else if (adv && s0_valid_ff && (s0_kind_ff == KIND_LOAD) &&
                      (s0_index_ff == 4'(e))) begin
            mat_ff[e] <= s0_value_ff;
         end
      end
   end

   // stage 1: full products
   logic               s1_valid_ff;
   logic signed [63:0] s1_prod_ff [0:ENTRY_COUNT-1];
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff && (s0_kind_ff == KIND_VERTEX);
      end
      if (adv) begin
         for (int e = 0; e < ENTRY_COUNT; e++) begin
            s1_prod_ff[e] <= mat_ff[e] * s0_vec_ff[e % MATRIX_SIZE];
         end
      end
   end

   // stage 2: pair sums
   logic               s2_valid_ff;
   logic signed [64:0] s2_pair_ff [0:ENTRY_COUNT/2-1];
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         for (int p = 0; p < ENTRY_COUNT/2; p++) begin
            s2_pair_ff[p] <= 65'(s1_prod_ff[2*p]) + 65'(s1_prod_ff[2*p+1]);
         end
      end
   end

   // stage 3: row sum, floor shift, saturate
   logic               s3_valid_ff;
   logic signed [31:0] s3_res_ff [0:MATRIX_SIZE-1];
   logic signed [31:0] s3_res_in [0:MATRIX_SIZE-1];
   always_comb begin
      logic signed [65:0] sum;
      logic signed [65:0] sh;
      for (int r = 0; r < MATRIX_SIZE; r++) begin
         sum = 66'(s2_pair_ff[2*r]) + 66'(s2_pair_ff[2*r+1]);
         sh  = sum >>> FRAC_BITS;
         if (sh > 66'(SAT_MAX)) begin
            s3_res_in[r] = SAT_MAX;
         end else if (sh < 66'(SAT_MIN)) begin
            s3_res_in[r] = SAT_MIN;
         end else begin
            s3_res_in[r] = sh[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s3_res_ff <= s3_res_in;
      end
   end

   // stage 4: window offsets, y flipped
   logic               s4_valid_ff;
   payload_type        s4_pay_ff;
   logic signed [32:0] s4_nx_ff, s4_ny_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s4_pay_ff.out_x        <= s3_res_ff[0];
         s4_pay_ff.out_y        <= s3_res_ff[1];
         s4_pay_ff.out_z        <= s3_res_ff[2];
         s4_pay_ff.out_w        <= s3_res_ff[3];
         s4_pay_ff.window_error <= win_err;
         s4_nx_ff <= 33'(s3_res_ff[0]) - 33'(win_left_ff);
         s4_ny_ff <= 33'(win_top_ff) - 33'(s3_res_ff[1]);
      end
   end

   // stage 5: viewport scaling as two partial products per axis
   logic               s5_valid_ff;
   payload_type        s5_pay_ff;
   logic signed [49:0] s5_xlo_ff, s5_ylo_ff;
   logic signed [48:0] s5_xhi_ff, s5_yhi_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (adv) begin
         s5_pay_ff <= s4_pay_ff;
         s5_xlo_ff <= s4_nx_ff * $signed({1'b0, vp_width_ff[15:0]});
         s5_xhi_ff <= s4_nx_ff * $signed(vp_width_ff[31:16]);
         s5_ylo_ff <= s4_ny_ff * $signed({1'b0, vp_height_ff[15:0]});
         s5_yhi_ff <= s4_ny_ff * $signed(vp_height_ff[31:16]);
      end
   end

   // stage 6: combine partial products
   logic               s6_valid_ff;
   payload_type        s6_pay_ff;
   logic signed [65:0] s6_numx_ff, s6_numy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (adv) begin
         s6_pay_ff  <= s5_pay_ff;
         s6_numx_ff <= (66'(s5_xhi_ff) <<< 16) + 66'(s5_xlo_ff);
         s6_numy_ff <= (66'(s5_yhi_ff) <<< 16) + 66'(s5_ylo_ff);
      end
   end

   // divider for both axes
   logic               dv_valid;
   payload_type        dv_pay;
   logic signed [31:0] dv_sx, dv_sy;

   vtvm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_valid_ff),
      .in_pay    (s6_pay_ff),
      .in_num_x  (s6_numx_ff),
      .in_num_y  (s6_numy_ff),
      .in_den_x  (win_dx),
      .in_den_y  (win_dy),
      .out_valid (dv_valid),
      .out_pay   (dv_pay),
      .out_sx    (dv_sx),
      .out_sy    (dv_sy)
   );

   // output register
   logic [191:0] rsp_data_ff;
   logic         rsp_err_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
      if (adv) begin
         rsp_data_ff <= {dv_sy, dv_sx, dv_pay.out_w, dv_pay.out_z,
                         dv_pay.out_y, dv_pay.out_x};
         rsp_err_ff  <= dv_pay.window_error;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

endmodule

`default_nettype wire

// ----- design/vtvm_div.sv -----
// vtvm_div: pipelined signed divider for both screen axes, one quotient bit a stage
// depends on vtvm_pkg
`default_nettype none

module vtvm_div
   import vtvm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire payload_type        in_pay,
   input  wire logic signed [65:0] in_num_x,
   input  wire logic signed [65:0] in_num_y,
   input  wire logic signed [32:0] in_den_x,
   input  wire logic signed [32:0] in_den_y,
   output logic                    out_valid,
   output payload_type             out_pay,
   output logic signed [31:0]      out_sx,
   output logic signed [31:0]      out_sy
);

   div_type     st_ff  [0:QUO_BITS][0:1];
   payload_type pay_ff [0:QUO_BITS];
   logic        vld_ff [0:QUO_BITS];

   div_type            st0_in [0:1];
   logic signed [65:0] num [0:1];
   logic signed [32:0] den [0:1];

   assign num[0] = in_num_x;
   assign num[1] = in_num_y;
   assign den[0] = in_den_x;
   assign den[1] = in_den_y;

   // sign and magnitude, overflow when the quotient needs more than 32 bits
   always_comb begin
      logic [65:0] nmag;
      logic [33:0] dmag;
      for (int a = 0; a < 2; a++) begin
         nmag = num[a][65] ? 66'(-num[a]) : num[a];
         dmag = den[a][32] ? 34'(-{den[a][32], den[a]}) : {1'b0, den[a]};
         if (dmag == '0) begin
            dmag = 34'd1;
         end
         st0_in[a].rem = nmag[63:0];
         st0_in[a].den = dmag[32:0];
         st0_in[a].quo = '0;
         st0_in[a].neg = num[a][65] ^ den[a][32];
         st0_in[a].ovf = {1'b0, nmag[63:0]} >= {dmag[32:0], 32'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         pay_ff[0]   <= in_pay;
         st_ff[0][0] <= st0_in[0];
         st_ff[0][1] <= st0_in[1];
      end
   end

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      localparam int BIT = QUO_BITS - 1 - k;
      div_type st_in [0:1];

      always_comb begin
         logic [64:0] shifted;
         for (int a = 0; a < 2; a++) begin
            st_in[a] = st_ff[k][a];
            shifted  = {32'b0, st_ff[k][a].den} << BIT;
            if (!st_ff[k][a].ovf && ({1'b0, st_ff[k][a].rem} >= shifted)) begin
               st_in[a].rem      = st_ff[k][a].rem - shifted[63:0];
               st_in[a].quo[BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (adv) begin
            pay_ff[k+1]   <= pay_ff[k];
            st_ff[k+1][0] <= st_in[0];
            st_ff[k+1][1] <= st_in[1];
         end
      end
   end

   // signed result with saturation, zero on a degenerate window
   logic signed [31:0] res [0:1];
   always_comb begin
      logic [32:0] q;
      for (int a = 0; a < 2; a++) begin
         q = {1'b0, st_ff[QUO_BITS][a].quo};
         if (st_ff[QUO_BITS][a].neg) begin
            if (st_ff[QUO_BITS][a].ovf || q > 33'h080000000) begin
               res[a] = SAT_MIN;
            end else begin
               res[a] = 32'(-q);
            end
         end else begin
            if (st_ff[QUO_BITS][a].ovf || q > 33'h07fffffff) begin
               res[a] = SAT_MAX;
            end else begin
               res[a] = q[31:0];
            end
         end
         if (pay_ff[QUO_BITS].window_error) begin
            res[a] = '0;
         end
      end
   end

   assign out_valid = vld_ff[QUO_BITS];
   assign out_pay   = pay_ff[QUO_BITS];
   assign out_sx    = res[0];
   assign out_sy    = res[1];

endmodule

`default_nettype wire
